@@ rtl/core/c_style_token_scanner_assert.svh @@
// assertion macros for the token scanner
`ifndef C_STYLE_TOKEN_SCANNER_ASSERT_SVH
`define C_STYLE_TOKEN_SCANNER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cts_pkg.sv @@
// types, constants and helper functions for the token scanner
`default_nettype none

package cts_pkg;

  localparam int LINE_BITS_DEF   = 20;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int COL_BITS        = 16;
  localparam int LEN_BITS        = 24;
  localparam int KIND_BITS       = 4;
  localparam int MAX_RESULTS     = 3;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SPACE    = 4'd0,
    KIND_IDENT    = 4'd1,
    KIND_OTHER    = 4'd2,
    KIND_NEWLINE  = 4'd3,
    KIND_LINECMT  = 4'd4,
    KIND_BLOCKCMT = 4'd5,
    KIND_DQ       = 4'd6,
    KIND_SQ       = 4'd7,
    KIND_EOF      = 4'd8,
    KIND_NONE     = 4'd15
  } kind_t;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  function automatic logic is_ident(input logic [7:0] c);
    return c[7] || (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_USCORE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/c_style_token_scanner.sv @@
// c-style token scanner top level: scan state, token decisions and result queue
//
// Input channel (in_valid/in_ready) takes one source byte per transaction in
// char_code; a zero byte or end_marker = 1 ends the text. Output channel
// (out_valid/out_ready) gives one token per transaction: kind, start line,
// column, offset, length, unclosed flag, and last_of_run on the final token
// caused by an input byte. One byte of lookahead is held, so a token comes out
// when the second byte after it arrives, or at the end of the text, which
// flushes the open token and adds an end-of-file token. After that every
// byte is taken and ignored until reset.
// All decisions for a byte are made in the cycle it is accepted; its tokens
// are written to a 4-entry queue and shown once earlier tokens have gone.
// One byte per cycle is accepted as long as the queue holds at most one token;
// a byte that ends the text can write three tokens, so in_ready drops while
// the queue drains one token per cycle as the receiver takes them.
// When the receiver stalls, in_ready falls as soon as two tokens wait in the
// queue. Reset (rst, synchronous) empties the queue and restarts at line 1.
`default_nettype none

module c_style_token_scanner #(
  parameter int LINE_BITS   = cts_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = cts_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   char_code,
  input  logic                         end_marker,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cts_pkg::KIND_BITS-1:0] token_kind,
  output logic [LINE_BITS-1:0]         start_line,
  output logic [cts_pkg::COL_BITS-1:0] start_column,
  output logic [OFFSET_BITS-1:0]       start_offset,
  output logic [cts_pkg::LEN_BITS-1:0] token_length,
  output logic                         unclosed,
  output logic                         last_of_run
);

  import cts_pkg::*;

  localparam int LW = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [COL_BITS-1:0]    col;
    logic [OFFSET_BITS-1:0] off;
    logic [LEN_BITS-1:0]    len;
    logic                   open;
    logic                   last;
  } res_t;

  localparam int RW = $bits(res_t);

  function automatic logic [LEN_BITS-1:0] tok_len(input logic [OFFSET_BITS-1:0] e,
                                                  input logic [OFFSET_BITS-1:0] s);
    logic [LW-1:0] d;
    d = (e >= s) ? LW'(e - s) : '0;
    return (d > LW'(LEN_MAX)) ? LEN_MAX : d[LEN_BITS-1:0];
  endfunction

  // scan state
  kind_t                  mode, mode_next;
  logic [7:0]             la_byte, la_byte_next;
  logic                   la_valid, la_valid_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [COL_BITS-1:0]    col, col_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COL_BITS-1:0]    tok_col, tok_col_next;
  logic [OFFSET_BITS-1:0] tok_off, tok_off_next;
  logic [OFFSET_BITS-1:0] byte_off, byte_off_next;
  logic                   done, done_next;
  logic                   closed, closed_next;
  logic                   skip, skip_next;

  logic                   accept;
  logic                   step_end;
  logic [7:0]             c;
  logic [7:0]             nb;
  logic [7:0]             quote;
  logic                   restart;
  res_t                   r0, r1, r2;
  logic [2:0]             lanes;
  logic [2:0]             push;
  logic [2:0][RW-1:0]     push_data;
  logic [RW-1:0]          q_data;
  res_t                   q;

  assign accept   = in_valid && in_ready;
  assign step_end = end_marker || (char_code == '0);
  assign c        = la_byte;
  assign nb       = step_end ? '0 : char_code;

  always_comb begin
    mode_next     = mode;
    la_byte_next  = la_byte;
    la_valid_next = la_valid;
    line_next     = line;
    col_next      = col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_off_next  = tok_off;
    byte_off_next = byte_off;
    done_next     = done;
    closed_next   = closed;
    skip_next     = skip;
    restart       = 1'b0;
    quote         = (mode == KIND_DQ) ? CH_DQUOTE : CH_SQUOTE;
    lanes         = '0;
    r0            = '0;
    r1            = '0;
    r2            = '0;

    // consume the lookahead byte
    if (!done && la_valid) begin
      col_next = (col != '1) ? col + 1'b1 : col;
      if (c == CH_LF) begin
        line_next = (line != '1) ? line + 1'b1 : line;
        col_next  = '0;
      end
      if (skip) begin
        skip_next = 1'b0;
      end else begin
        if (mode == KIND_NONE || closed) begin
          restart = 1'b1;
        end else begin
          unique case (mode)
            KIND_SPACE:   restart = !is_blank(c);
            KIND_IDENT:   restart = !is_ident(c);
            KIND_LINECMT: restart = (c == CH_CR) || (c == CH_LF);
            KIND_BLOCKCMT: begin
              if (c == CH_STAR && nb == CH_SLASH) begin
                closed_next = 1'b1;
                skip_next   = 1'b1;
              end
            end
            KIND_DQ, KIND_SQ: begin
              if (c == CH_BSLASH && nb == quote) begin
                skip_next = 1'b1;
              end else if (c == quote) begin
                closed_next = 1'b1;
              end
            end
            default:      restart = 1'b1;
          endcase
        end
        if (restart) begin
          if (mode != KIND_NONE) begin
            lanes[0]      = 1'b1;
            r0.kind       = mode;
            r0.line       = tok_line;
            r0.col        = tok_col;
            r0.off        = tok_off;
            r0.len        = tok_len(byte_off, tok_off);
            r0.open       = 1'b0;
            r0.last       = !step_end;
            tok_line_next = line_next;
            tok_col_next  = col_next;
          end
          tok_off_next = byte_off;
          closed_next  = 1'b0;
          priority if (c == CH_SLASH && nb == CH_SLASH) begin
            mode_next = KIND_LINECMT;
            skip_next = 1'b1;
          end else if (c == CH_SLASH && nb == CH_STAR) begin
            mode_next = KIND_BLOCKCMT;
            skip_next = 1'b1;
          end else if (c == CH_DQUOTE) begin
            mode_next = KIND_DQ;
          end else if (c == CH_SQUOTE) begin
            mode_next = KIND_SQ;
          end else if (is_blank(c)) begin
            mode_next = KIND_SPACE;
          end else if (is_ident(c)) begin
            mode_next = KIND_IDENT;
          end else if (c == CH_LF) begin
            mode_next   = KIND_NEWLINE;
            closed_next = 1'b1;
          end else if (c == CH_CR && nb == CH_LF) begin
            mode_next   = KIND_NEWLINE;
            closed_next = 1'b1;
            skip_next   = 1'b1;
          end else begin
            mode_next   = KIND_OTHER;
            closed_next = 1'b1;
          end
        end
      end
      byte_off_next = (byte_off != '1) ? byte_off + 1'b1 : byte_off;
    end

    // end of text: flush the open token, then end-of-file
    if (!done) begin
      if (step_end) begin
        if (mode_next != KIND_NONE) begin
          lanes[1] = 1'b1;
          r1.kind  = mode_next;
          r1.line  = tok_line_next;
          r1.col   = tok_col_next;
          r1.off   = tok_off_next;
          r1.len   = tok_len(byte_off_next, tok_off_next);
          r1.open  = !closed_next && (mode_next == KIND_BLOCKCMT ||
                     mode_next == KIND_DQ || mode_next == KIND_SQ);
          r1.last  = 1'b0;
        end
        lanes[2]      = 1'b1;
        r2.kind       = KIND_EOF;
        r2.line       = line_next;
        r2.col        = '0;
        r2.off        = byte_off_next;
        r2.len        = '0;
        r2.open       = 1'b0;
        r2.last       = 1'b1;
        mode_next     = KIND_NONE;
        closed_next   = 1'b0;
        skip_next     = 1'b0;
        la_valid_next = 1'b0;
        done_next     = 1'b1;
      end else begin
        la_byte_next  = char_code;
        la_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= KIND_NONE;
      la_byte  <= '0;
      la_valid <= 1'b0;
      line     <= LINE_BITS'(1);
      col      <= '0;
      tok_line <= LINE_BITS'(1);
      tok_col  <= COL_BITS'(1);
      tok_off  <= '0;
      byte_off <= '0;
      done     <= 1'b0;
      closed   <= 1'b0;
      skip     <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      la_byte  <= la_byte_next;
      la_valid <= la_valid_next;
      line     <= line_next;
      col      <= col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_off  <= tok_off_next;
      byte_off <= byte_off_next;
      done     <= done_next;
      closed   <= closed_next;
      skip     <= skip_next;
    end
  end

  assign push         = accept ? lanes : 3'b000;
  assign push_data[0] = r0;
  assign push_data[1] = r1;
  assign push_data[2] = r2;

  cts_rqueue #(
    .W     (RW),
    .DEPTH (QUEUE_DEPTH),
    .LANES (MAX_RESULTS)
  ) u_rqueue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign q            = res_t'(q_data);
  assign token_kind   = q.kind;
  assign start_line   = q.line;
  assign start_column = q.col;
  assign start_offset = q.off;
  assign token_length = q.len;
  assign unclosed     = q.open;
  assign last_of_run  = q.last;

  `include "c_style_token_scanner_assert.svh"

  `CTS_ASSERT_IMP(a_quiet_after_end, done, push == 3'b000, "token written after end of text")
  `CTS_ASSERT_NEXT(a_end_closes, accept && step_end, done, "end of text did not close stream")
  `CTS_ASSERT_IMP(a_stall_has_backlog, !in_ready, out_valid, "input stalled with empty queue")

endmodule

`default_nettype wire

@@ rtl/core/cts_rqueue.sv @@
// result queue: up to LANES writes per cycle in lane order, one read per cycle while out_ready is high
`default_nettype none

module cts_rqueue #(
  parameter int W     = 8,
  parameter int DEPTH = 4,
  parameter int LANES = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [LANES-1:0]          push,
  input  logic [LANES-1:0][W-1:0]   push_data,
  output logic                      space,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [W-1:0]              out_data
);

  // depth is a power of two so the pointers wrap naturally
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] n_push;
  logic [PW-1:0] lane_pos [LANES];
  logic          pop;

  always_comb begin
    n_push = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_pos[i] = wr_ptr + PW'(n_push);
      n_push      = n_push + CW'(push[i]);
    end
  end

  assign out_valid  = (count != '0);
  assign out_data   = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign space      = (count <= CW'(DEPTH - LANES));
  assign count_next = count + n_push - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (push[i]) begin
        mem[lane_pos[i]] <= push_data[i];
      end
    end
  end

endmodule

`default_nettype wire
